@@ src/bdrm_pkg.sv @@
`timescale 1ns / 1ps
package bdrm_pkg;

  localparam int unsigned WordW = 64;

  typedef enum logic [2:0] {
    ActLoadRef  = 3'd0,
    ActLoadCand = 3'd1,
    ActRun      = 3'd2,
    ActRead     = 3'd3,
    ActClear    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2
  } status_e;

  localparam logic [0:0] CfgThreshold = 1'b0;
  localparam logic [0:0] CfgRatio     = 1'b1;

  localparam logic [8:0] DistUnset   = 9'h1FF;
  localparam logic [8:0] NoMatchDist = 9'd256;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] desc_word0;
    logic [63:0] desc_word1;
    logic [63:0] desc_word2;
    logic [63:0] desc_word3;
    logic [8:0]  ref_index;
  } req_t;

  typedef struct packed {
    logic signed [9:0] matched_candidate;
    logic [8:0]        match_distance;
    logic [9:0]        match_total;
    logic [1:0]        status;
  } rsp_t;

  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [6:0] s;
    s = '0;
    for (int i = 0; i < 64; i++) s = s + 7'(v[i]);
    return s;
  endfunction

endpackage

@@ src/bdrm_dist.sv @@
`timescale 1ns / 1ps
// Accumulates the Hamming distance one 64-bit word per cycle.
module bdrm_dist
  import bdrm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             add_i,
  input  logic [WordW-1:0] a_i,
  input  logic [WordW-1:0] b_i,
  output logic [11:0]      dist_o
);

  logic [6:0]  pc_q;
  logic        pc_vld_q;
  logic [11:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_vld_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      pc_vld_q <= add_i;
      if (start_i) begin
        acc_q <= '0;
      end else if (pc_vld_q) begin
        acc_q <= acc_q + 12'(pc_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q <= popcount64(a_i ^ b_i);
  end

  assign dist_o = acc_q;

endmodule

@@ src/binary_descriptor_ratio_matcher.sv @@
`timescale 1ns / 1ps
// Binary descriptor matcher with a nearest / second-nearest ratio test.
// Requests enter on req_valid_i / req_stall_o with one packed req_t and each
// request produces exactly one rsp_t on rsp_valid_o / rsp_stall_i.
// A load passes through S_LOAD, writing one descriptor word a cycle unless
// its list is full, and answers from S_RSP. A read passes through S_TRD and
// S_TRD2, and through S_OWNRD2 and S_OWNRD when it finds a match and fetches
// the distance from the candidate table, before it answers from S_RSP. A
// clear answers in the cycle after it is taken, an unknown action by way of
// S_RSP. The next request is only taken once the response has gone. A run
// request first clears the match tables in a pass over max(MAX_REFERENCES,
// MAX_CANDIDATES) table entries, then walks every reference against every
// candidate, one 64-bit word a cycle, and answers when the walk is done.
// A clear request runs the same pass, entered as its response is raised.
// After reset the same clearing pass runs before the first request is taken;
// the configuration port stays open throughout. A stalled response holds its
// payload and no new request is taken until it has gone.
module binary_descriptor_ratio_matcher
  import bdrm_pkg::*;
#(
  parameter int unsigned MAX_REFERENCES = 512,
  parameter int unsigned MAX_CANDIDATES = 512,
  parameter int unsigned DESC_WORDS     = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_stall_o,
  input  req_t       req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_stall_i,
  output rsp_t       rsp_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  localparam int unsigned RW   = $clog2(MAX_REFERENCES);
  localparam int unsigned CW   = $clog2(MAX_CANDIDATES);
  localparam int unsigned WW   = (DESC_WORDS > 1) ? $clog2(DESC_WORDS) : 1;
  localparam int unsigned RAW  = RW + WW;
  localparam int unsigned CAW  = CW + WW;
  localparam int unsigned RCW  = $clog2(MAX_REFERENCES + 1);
  localparam int unsigned CCW  = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned MAXN = (MAX_REFERENCES > MAX_CANDIDATES) ?
                                 MAX_REFERENCES : MAX_CANDIDATES;
  localparam int unsigned SW   = $clog2(MAXN + 1);
  localparam int unsigned MCW  = $clog2(MAX_REFERENCES + 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD, S_TRD, S_TRD2, S_RSP,
    S_RSTART, S_WADDR, S_WDRAIN, S_WDRAIN2, S_OWNRD, S_OWNRD2, S_CMP,
    S_DEC, S_PREV, S_COMMIT, S_NEXTR
  } state_e;

  state_e state_q;

  // Each descriptor takes a slot of 2**WW words, addressed as {entry, word}.
  logic [WordW-1:0] ref_mem  [MAX_REFERENCES << WW];
  logic [WordW-1:0] cand_mem [MAX_CANDIDATES << WW];
  logic [CW:0]      mor_mem  [MAX_REFERENCES];   // candidate + 1, zero none
  logic [RW:0]      own_mem  [MAX_CANDIDATES];   // reference + 1, zero none
  logic [8:0]       bd_mem   [MAX_CANDIDATES];

  logic [8:0] thr_q, ratio_q;
  logic [RCW-1:0] rcnt_q;
  logic [CCW-1:0] ccnt_q;
  logic [MCW-1:0] mcnt_q;
  req_t  req_q;
  rsp_t  rsp_q;
  logic  rsp_vld_q;
  logic  run_after_clr_q;
  logic [SW-1:0] sweep_q;

  logic [RW-1:0] r_q;
  logic [CW-1:0] c_q;
  logic [WW:0]   w_q;
  logic          have1_q, have2_q;
  logic [8:0]    best_q, best2_q;
  logic [CW-1:0] idx_q;
  logic [RW:0]   own_rd_q;
  logic [CW:0]   mor_rd_q;
  logic [8:0]    bd_rd_q;
  logic [WordW-1:0] ref_rd_q, cand_rd_q;

  logic dist_start, dist_add;
  logic [11:0] dist_sum;

  bdrm_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .add_i   (dist_add),
    .a_i     (ref_rd_q),
    .b_i     (cand_rd_q),
    .dist_o  (dist_sum)
  );

  assign cfg_ready_o = 1'b1;
  assign req_stall_o = (state_q != S_IDLE) || rsp_vld_q;
  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  wire req_acc = req_valid_i && !req_stall_o;

  logic [WordW-1:0] wsel;
  always_comb begin
    unique case (w_q[1:0])
      2'd0: wsel = req_q.desc_word0;
      2'd1: wsel = req_q.desc_word1;
      2'd2: wsel = req_q.desc_word2;
      default: wsel = req_q.desc_word3;
    endcase
    if (32'(w_q) >= 4) wsel = '0;
  end

  wire [8:0] d9 = dist_sum[8:0];
  wire skip = (own_rd_q != '0) && (bd_rd_q <= d9);
  wire [17:0] lhs = {1'b0, best_q, 8'd0};
  wire [17:0] rhs = 18'(best2_q) * 18'(ratio_q);
  wire keep = have1_q && (best_q <= thr_q) && (!have2_q || (lhs < rhs));
  wire last_c = (32'(c_q) + 1 >= 32'(ccnt_q));
  wire last_r = (32'(r_q) + 1 >= 32'(rcnt_q));

  // Memory ports: descriptor reads in the walk, loads write.
  always_ff @(posedge clk_i) begin
    ref_rd_q  <= ref_mem[RAW'({r_q, WW'(w_q)})];
    cand_rd_q <= cand_mem[CAW'({c_q, WW'(w_q)})];
    if (state_q == S_LOAD && req_q.action == ActLoadRef && rcnt_q < RCW'(MAX_REFERENCES))
      ref_mem[RAW'({rcnt_q[RW-1:0], WW'(w_q)})] <= wsel;
    if (state_q == S_LOAD && req_q.action == ActLoadCand && ccnt_q < CCW'(MAX_CANDIDATES))
      cand_mem[CAW'({ccnt_q[CW-1:0], WW'(w_q)})] <= wsel;
  end

  logic [RW-1:0] mor_ra;
  logic [CW-1:0] own_ra;
  always_comb begin
    mor_ra = r_q;
    own_ra = c_q;
    if (state_q == S_TRD || state_q == S_TRD2) mor_ra = RW'(req_q.ref_index);
    if (state_q == S_OWNRD2) own_ra = mor_rd_q[CW-1:0] - 1'b1;
    if (state_q == S_DEC) own_ra = idx_q;
  end

  always_ff @(posedge clk_i) begin
    mor_rd_q <= mor_mem[mor_ra];
    own_rd_q <= own_mem[own_ra];
    bd_rd_q  <= bd_mem[own_ra];
    if (state_q == S_CLR) begin
      if (32'(sweep_q) < MAX_REFERENCES) mor_mem[sweep_q[RW-1:0]] <= '0;
      if (32'(sweep_q) < MAX_CANDIDATES) begin
        own_mem[sweep_q[CW-1:0]] <= '0;
        bd_mem[sweep_q[CW-1:0]]  <= DistUnset;
      end
    end else if (state_q == S_PREV && own_rd_q != '0) begin
      mor_mem[RW'(own_rd_q - 1'b1)] <= '0;
    end else if (state_q == S_COMMIT) begin
      mor_mem[r_q]     <= (CW+1)'(idx_q) + 1'b1;
      own_mem[idx_q]   <= (RW+1)'(r_q) + 1'b1;
      bd_mem[idx_q]    <= best_q;
    end
  end

  always_comb begin
    dist_start = (state_q == S_WADDR) && (w_q == '0);
    dist_add   = (state_q == S_WADDR && w_q != '0) || state_q == S_WDRAIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      sweep_q <= '0;
      thr_q <= 9'd60;
      ratio_q <= 9'd230;
      rcnt_q <= '0;
      ccnt_q <= '0;
      mcnt_q <= '0;
      rsp_vld_q <= 1'b0;
      run_after_clr_q <= 1'b0;
      r_q <= '0; c_q <= '0; w_q <= '0;
      have1_q <= 1'b0; have2_q <= 1'b0;
      best_q <= '0; best2_q <= '0; idx_q <= '0;
      req_q <= '0; rsp_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgThreshold: thr_q <= cfg_data_i;
          default:      ratio_q <= cfg_data_i;
        endcase
      end
      if (rsp_vld_q && !rsp_stall_i) rsp_vld_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          sweep_q <= sweep_q + 1'b1;
          if (32'(sweep_q) == MAXN - 1) begin
            sweep_q <= '0;
            mcnt_q <= '0;
            if (run_after_clr_q) begin
              run_after_clr_q <= 1'b0;
              r_q <= '0;
              state_q <= (rcnt_q == '0 || ccnt_q == '0) ? S_RSP : S_RSTART;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_IDLE: if (req_acc) begin
          req_q <= req_i;
          w_q <= '0;
          rsp_q.matched_candidate <= -10'sd1;
          rsp_q.match_distance <= NoMatchDist;
          rsp_q.status <= StOk;
          unique case (req_i.action)
            ActLoadRef, ActLoadCand: state_q <= S_LOAD;
            ActRun: begin
              run_after_clr_q <= 1'b1;
              state_q <= S_CLR;
            end
            ActRead: state_q <= S_TRD;
            ActClear: begin
              rcnt_q <= '0;
              ccnt_q <= '0;
              state_q <= S_CLR;
              rsp_q.match_total <= '0;
              rsp_vld_q <= 1'b1;
            end
            default: state_q <= S_RSP;
          endcase
        end
        S_LOAD: begin
          w_q <= w_q + 1'b1;
          if (32'(w_q) == DESC_WORDS - 1) begin
            state_q <= S_RSP;
            if (req_q.action == ActLoadRef) begin
              if (rcnt_q < RCW'(MAX_REFERENCES)) rcnt_q <= rcnt_q + 1'b1;
              else rsp_q.status <= StFull;
            end else begin
              if (ccnt_q < CCW'(MAX_CANDIDATES)) ccnt_q <= ccnt_q + 1'b1;
              else rsp_q.status <= StFull;
            end
          end
        end
        S_TRD: state_q <= S_TRD2;
        S_TRD2: begin
          if (32'(req_q.ref_index) >= 32'(rcnt_q)) begin
            rsp_q.status <= StRange;
            state_q <= S_RSP;
          end else begin
            state_q <= S_RSP;
            if (mor_rd_q != '0) begin
              rsp_q.matched_candidate <= 10'(mor_rd_q - 1'b1);
              state_q <= S_OWNRD2;
            end
          end
        end
        S_OWNRD2: state_q <= S_OWNRD;
        S_OWNRD: begin
          rsp_q.match_distance <= bd_rd_q;
          state_q <= S_RSP;
        end
        S_RSP: begin
          rsp_q.match_total <= 10'(mcnt_q);
          rsp_vld_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_RSTART: begin
          c_q <= '0; w_q <= '0;
          have1_q <= 1'b0; have2_q <= 1'b0;
          best_q <= '0; best2_q <= '0; idx_q <= '0;
          state_q <= S_WADDR;
        end
        S_WADDR: begin
          w_q <= w_q + 1'b1;
          if (32'(w_q) == DESC_WORDS - 1) state_q <= S_WDRAIN;
        end
        S_WDRAIN: state_q <= S_WDRAIN2;
        S_WDRAIN2: state_q <= S_CMP;
        S_CMP: begin
          if (!skip) begin
            if (!have1_q || d9 < best_q) begin
              best2_q <= best_q; have2_q <= have1_q;
              best_q <= d9; idx_q <= c_q; have1_q <= 1'b1;
            end else if (!have2_q || d9 < best2_q) begin
              best2_q <= d9; have2_q <= 1'b1;
            end
          end
          w_q <= '0;
          if (last_c) state_q <= S_DEC;
          else begin
            c_q <= c_q + 1'b1;
            state_q <= S_WADDR;
          end
        end
        S_DEC: state_q <= keep ? S_PREV : S_NEXTR;
        S_PREV: begin
          if (own_rd_q != '0) mcnt_q <= mcnt_q - 1'b1;
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          mcnt_q <= mcnt_q + 1'b1;
          state_q <= S_NEXTR;
        end
        S_NEXTR: begin
          if (last_r) state_q <= S_RSP;
          else begin
            r_q <= r_q + 1'b1;
            state_q <= S_RSTART;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/bdrm_checker.sv @@
`timescale 1ns / 1ps
module bdrm_checker
  import bdrm_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_stall_o,
  input logic rsp_valid_o,
  input logic rsp_stall_i,
  input rsp_t rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  a_no_take_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o)
    else $error("request taken with response pending");

  a_range_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status == StRange |-> rsp_o.matched_candidate == -10'sd1)
    else $error("out of range read reported a match");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.status == StOk || rsp_o.status == StFull ||
                     rsp_o.status == StRange))
    else $error("bad status");

endmodule

bind binary_descriptor_ratio_matcher bdrm_checker u_bdrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_stall_o (req_stall_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_stall_i (rsp_stall_i),
  .rsp_o       (rsp_o)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import bdrm_pkg::*;

  localparam int unsigned NumRefs   = 512;
  localparam int unsigned NumCands  = 512;
  localparam longint      CycleCap  = 3_000_000;
  localparam logic [9:0]  NoCand    = 10'h3FF;
  localparam int          ReqW      = $bits(req_t);

  logic       clk_i;
  logic       rst_ni;
  logic       req_valid_i;
  logic       req_stall_o;
  req_t       req_i;
  logic       rsp_valid_o;
  logic       rsp_stall_i;
  rsp_t       rsp_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [0:0] cfg_index_i;
  logic [8:0] cfg_data_i;

  binary_descriptor_ratio_matcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow of the matcher state.
  logic [255:0] ref_desc  [NumRefs];
  logic [255:0] cand_desc [NumCands];
  int unsigned  ref_total;
  int unsigned  cand_total;
  logic [9:0]   ref_match  [NumRefs];
  logic [9:0]   cand_owner [NumCands];
  logic [8:0]   cand_dist  [NumCands];
  int unsigned  matches_held;
  logic [8:0]   threshold;
  logic [8:0]   ratio;

  req_t   pending_reqs[$];
  rsp_t   expected_rsps[$];
  int     errors;
  int     queued;
  int     send_gap;
  int     stall_left;
  bit     quiet;
  longint cycles;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic void clear_tables();
    for (int i = 0; i < NumRefs; i++) ref_match[i] = '0;
    for (int i = 0; i < NumCands; i++) begin
      cand_owner[i] = '0;
      cand_dist[i]  = DistUnset;
    end
    matches_held = 0;
  endfunction

  function automatic void match_all();
    int  best;
    int  best2;
    int  idx;
    int  d;
    bit  have1;
    bit  have2;
    clear_tables();
    for (int r = 0; r < ref_total; r++) begin
      have1 = 0;
      have2 = 0;
      best  = 0;
      best2 = 0;
      idx   = 0;
      for (int c = 0; c < cand_total; c++) begin
        d = $countones(ref_desc[r] ^ cand_desc[c]);
        if (cand_owner[c] != 0 && int'(cand_dist[c]) <= d) continue;
        if (!have1 || d < best) begin
          best2 = best;
          have2 = have1;
          best  = d;
          idx   = c;
          have1 = 1;
        end else if (!have2 || d < best2) begin
          best2 = d;
          have2 = 1;
        end
      end
      if (!have1 || best > int'(threshold)) continue;
      if (have2 && !(best * 256 < best2 * int'(ratio))) continue;
      // The candidate is taken from whichever earlier reference held it.
      if (cand_owner[idx] != 0) begin
        ref_match[cand_owner[idx] - 1] = '0;
        matches_held--;
      end
      ref_match[r]      = 10'(idx + 1);
      cand_owner[idx]   = 10'(r + 1);
      cand_dist[idx]    = 9'(best);
      matches_held++;
    end
  endfunction

  function automatic rsp_t predict_match(req_t q);
    rsp_t         o;
    logic [255:0] d;
    o.matched_candidate = NoCand;
    o.match_distance    = NoMatchDist;
    o.status            = StOk;
    d = {q.desc_word3, q.desc_word2, q.desc_word1, q.desc_word0};
    unique case (q.action)
      ActLoadRef: begin
        if (ref_total < NumRefs) begin
          ref_desc[ref_total] = d;
          ref_total++;
        end else begin
          o.status = StFull;
        end
      end
      ActLoadCand: begin
        if (cand_total < NumCands) begin
          cand_desc[cand_total] = d;
          cand_total++;
        end else begin
          o.status = StFull;
        end
      end
      ActRun: match_all();
      ActRead: begin
        if (q.ref_index >= ref_total) begin
          o.status = StRange;
        end else if (ref_match[q.ref_index] != 0) begin
          o.matched_candidate = ref_match[q.ref_index] - 10'd1;
          o.match_distance    = cand_dist[ref_match[q.ref_index] - 1];
        end
      end
      ActClear: begin
        ref_total  = 0;
        cand_total = 0;
        clear_tables();
      end
      default: ;
    endcase
    o.match_total = 10'(matches_held);
    return o;
  endfunction

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && !req_stall_o) expected_rsps = {expected_rsps, predict_match(req_i)};
      if (!req_valid_i || !req_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid_i <= 1'b0;
        end else if (!quiet && pending_reqs.size() > 0 && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(1, 19) - 1;
          req_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_valid_i <= 1'b1;
          req_i       <= pending_reqs.pop_front();
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response monitor.
  always @(posedge clk_i) begin
    rsp_t e;
    cycles++;
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("[binary_descriptor_ratio_matcher] ERROR");
      $finish;
    end
    if (rst_ni) begin
      if (rsp_valid_o && !rsp_stall_i) begin
        if (expected_rsps.size() == 0) begin
          report("response with no request outstanding");
        end else begin
          e = expected_rsps.pop_front();
          if (rsp_o.matched_candidate !== e.matched_candidate)
            report($sformatf("matched_candidate %0d, expected %0d",
                             rsp_o.matched_candidate, e.matched_candidate));
          if (rsp_o.match_distance !== e.match_distance)
            report($sformatf("match_distance %0d, expected %0d",
                             rsp_o.match_distance, e.match_distance));
          if (rsp_o.match_total !== e.match_total)
            report($sformatf("match_total %0d, expected %0d",
                             rsp_o.match_total, e.match_total));
          if (rsp_o.status !== e.status)
            report($sformatf("status %0d, expected %0d", rsp_o.status, e.status));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        rsp_stall_i <= 1'b1;
      end else begin
        rsp_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [255:0] random_desc();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  function automatic logic [255:0] nearby_desc(logic [255:0] base, int flips);
    logic [255:0] v;
    v = base;
    repeat (flips) v[$urandom_range(0, 255)] ^= 1'b1;
    return v;
  endfunction

  task automatic push(input action_e act, input logic [255:0] d, input logic [8:0] idx);
    req_t q;
    q.action     = act;
    q.desc_word0 = d[63:0];
    q.desc_word1 = d[127:64];
    q.desc_word2 = d[191:128];
    q.desc_word3 = d[255:192];
    q.ref_index  = idx;
    pending_reqs = {pending_reqs, q};
    queued++;
  endtask

  // Unused fields carry random content so they are shown to be ignored.
  task automatic push_bare(input logic [2:0] act, input logic [8:0] idx);
    req_t q;
    q            = req_t'(ReqW'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom}));
    q.action     = act;
    q.ref_index  = idx;
    pending_reqs = {pending_reqs, q};
    queued++;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_valid_i || expected_rsps.size() != 0);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [8:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgThreshold) threshold = value;
    else ratio = value;
  endtask

  function automatic logic [8:0] pick_reg_value();
    unique case ($urandom_range(0, 4))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'($urandom_range(150, 256));
      default: return 9'($urandom_range(0, 256));
    endcase
  endfunction

  task automatic random_phase();
    logic [255:0] bases[4];
    int           nr;
    int           nc;
    int           held_refs;
    if ($urandom_range(0, 2) == 0) write_reg(CfgThreshold, pick_reg_value());
    if ($urandom_range(0, 2) == 0) write_reg(CfgRatio, pick_reg_value());
    if (ref_total > 16 || cand_total > 16 || $urandom_range(0, 3) != 0)
      push_bare(ActClear, 9'($urandom));
    for (int i = 0; i < 4; i++) bases[i] = random_desc();
    nr = $urandom_range(0, 8);
    nc = $urandom_range(0, 8);
    while (nr > 0 || nc > 0) begin
      if (nr > 0 && (nc == 0 || $urandom_range(0, 1) == 0)) begin
        push(ActLoadRef, nearby_desc(bases[$urandom_range(0, 3)], $urandom_range(0, 60)),
             9'($urandom));
        nr--;
      end else begin
        push(ActLoadCand, $urandom_range(0, 9) == 0 ? random_desc() :
             nearby_desc(bases[$urandom_range(0, 3)], $urandom_range(0, 60)), 9'($urandom));
        nc--;
      end
      if ($urandom_range(0, 15) == 0) push_bare(3'($urandom_range(5, 7)), 9'($urandom));
    end
    push_bare(ActRun, 9'($urandom));
    // Reads walk every loaded reference and a couple beyond the end.
    drain();
    held_refs = ref_total;
    for (int i = 0; i < held_refs + 2; i++) push_bare(ActRead, 9'(i));
    push_bare(ActRead, 9'($urandom));
    if ($urandom_range(0, 4) == 0) push_bare(ActRun, 9'($urandom));
    drain();
  endtask

  // A candidate close to the first reference, so a full-list run has a match.
  function automatic logic [255:0] ref_desc_probe();
    return nearby_desc(ref_desc[0], 1);
  endfunction

  initial begin
    logic [255:0] d;
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    rsp_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    errors      = 0;
    queued      = 0;
    send_gap    = 0;
    stall_left  = 0;
    quiet       = 0;
    cycles      = 0;
    ref_total   = 0;
    cand_total  = 0;
    threshold   = 9'd60;
    ratio       = 9'd230;
    clear_tables();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty store, unknown actions, extreme descriptors.
    push_bare(ActRead, 9'd0);
    push_bare(3'd5, 9'd511);
    push_bare(3'd6, 9'd0);
    push_bare(3'd7, 9'd1);
    push_bare(ActRun, 9'd0);
    d = random_desc();
    push(ActLoadRef, '0, 9'd0);
    push(ActLoadRef, '1, 9'd0);
    push(ActLoadRef, d, 9'd0);
    push_bare(ActRun, 9'd0);
    push_bare(ActRead, 9'd0);
    push(ActLoadCand, '1, 9'd0);
    push(ActLoadCand, '0, 9'd0);
    push(ActLoadCand, nearby_desc(d, 1), 9'd0);
    push_bare(ActRun, 9'd0);
    for (int i = 0; i < 4; i++) push_bare(ActRead, 9'(i));
    push_bare(ActRead, 9'd511);
    push_bare(ActClear, 9'd0);
    push_bare(ActRead, 9'd0);
    drain();
    write_reg(CfgThreshold, 9'd256);
    write_reg(CfgRatio, 9'd256);
    push(ActLoadRef, d, 9'd0);
    push(ActLoadCand, '1, 9'd0);
    push_bare(ActRun, 9'd0);
    push_bare(ActRead, 9'd0);
    drain();

    // Reference list filled to the brim, one load dropped.
    push_bare(ActClear, 9'd0);
    for (int i = 0; i <= NumRefs; i++) push(ActLoadRef, random_desc(), 9'($urandom));
    drain();
    push(ActLoadCand, ref_desc_probe(), 9'd0);
    push(ActLoadCand, nearby_desc(ref_desc[NumRefs - 1], 2), 9'd0);
    push_bare(ActRun, 9'd0);
    for (int i = 0; i < 6; i++) push_bare(ActRead, 9'(NumRefs - 1 - i));
    push_bare(ActRead, 9'($urandom));
    drain();

    // Candidate list filled to the brim, one load dropped; the last one stored matches.
    write_reg(CfgThreshold, 9'd60);
    push_bare(ActClear, 9'd0);
    d = random_desc();
    push(ActLoadRef, random_desc(), 9'd0);
    push(ActLoadRef, d, 9'd0);
    for (int i = 0; i < NumCands - 1; i++) push(ActLoadCand, random_desc(), 9'd0);
    push(ActLoadCand, nearby_desc(d, 3), 9'd0);
    push(ActLoadCand, d, 9'd0);
    push_bare(ActRun, 9'd0);
    push_bare(ActRead, 9'd0);
    push_bare(ActRead, 9'd1);
    push_bare(ActRead, 9'd2);
    drain();

    while (queued < 1750) random_phase();
    quiet = 1;
    while (queued < 1850) random_phase();

    drain();
    repeat (600) @(posedge clk_i);
    if (errors == 0) begin
      $display("[binary_descriptor_ratio_matcher] OK");
    end else begin
      $display("[binary_descriptor_ratio_matcher] ERROR");
    end
    $finish;
  end

endmodule
